### rtl/mlm_pkg.sv
// mlm_pkg: shared constants, opcodes and control/status structs for the
// modularity local-move core. Used by every module in rtl/.
package mlm_pkg;

  localparam int VID_W   = 12;
  localparam int NV      = 1 << VID_W;
  localparam int WT_W    = 24;
  localparam int CW_W    = 40;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 13;
  localparam int MAX_DEG = 256;
  localparam int DEG_W   = $clog2(MAX_DEG);
  localparam int EC_W    = DEG_W + 1;
  localparam int OP_W    = 5;

  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_DECIDE = 2'd2;
  localparam logic [1:0] MODE_FORCE  = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_CLR       = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd2;
  localparam logic [OP_W-1:0] OP_INIT_M1   = 5'd3;
  localparam logic [OP_W-1:0] OP_INIT_M2   = 5'd4;
  localparam logic [OP_W-1:0] OP_INIT_FIN  = 5'd5;
  localparam logic [OP_W-1:0] OP_EDGE_R1   = 5'd6;
  localparam logic [OP_W-1:0] OP_EDGE_R2   = 5'd7;
  localparam logic [OP_W-1:0] OP_EDGE_FIN  = 5'd8;
  localparam logic [OP_W-1:0] OP_EDGE_FULL = 5'd9;
  localparam logic [OP_W-1:0] OP_MV_R1     = 5'd10;
  localparam logic [OP_W-1:0] OP_MV_R2     = 5'd11;
  localparam logic [OP_W-1:0] OP_MV_OWN    = 5'd12;
  localparam logic [OP_W-1:0] OP_WALK_RD   = 5'd13;
  localparam logic [OP_W-1:0] OP_WALK_CL   = 5'd14;
  localparam logic [OP_W-1:0] OP_WALK_CHK  = 5'd15;
  localparam logic [OP_W-1:0] OP_F_RD      = 5'd16;
  localparam logic [OP_W-1:0] OP_F_LD      = 5'd17;
  localparam logic [OP_W-1:0] OP_G_M1      = 5'd18;
  localparam logic [OP_W-1:0] OP_G_M2      = 5'd19;
  localparam logic [OP_W-1:0] OP_G_CMP     = 5'd20;
  localparam logic [OP_W-1:0] OP_AP_R      = 5'd21;
  localparam logic [OP_W-1:0] OP_AP_1      = 5'd22;
  localparam logic [OP_W-1:0] OP_AP_2      = 5'd23;
  localparam logic [OP_W-1:0] OP_FC_RD     = 5'd24;
  localparam logic [OP_W-1:0] OP_FC_WR     = 5'd25;
  localparam logic [OP_W-1:0] OP_FIN       = 5'd26;
  localparam logic [OP_W-1:0] OP_RESULT    = 5'd27;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       edge_full;
    logic       walk_end;
    logic       tin_zero;
    logic       same_cluster;
    logic       found;
    logic       mul_done;
    logic       clr_done;
  } dp_stat_t;

endpackage

### rtl/mlm_mul.sv
// mlm_mul: 64x64 multiplier, product kept modulo 2^64, built from three
// 32x32 partial products computed in turn. Depends on mlm_pkg.
module mlm_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mlm_pkg::ACC_W-1:0]  a,
  input  logic [mlm_pkg::ACC_W-1:0]  b,
  output logic                       done,
  output logic [mlm_pkg::ACC_W-1:0]  p
);
  import mlm_pkg::*;

  localparam int HW = ACC_W / 2;

  logic [ACC_W-1:0] ra;
  logic [ACC_W-1:0] rb;
  logic [1:0]       step;
  logic             busy;
  logic [HW-1:0]    pa;
  logic [HW-1:0]    pb;
  logic [ACC_W-1:0] prod;

  // low*low, then the two cross terms shifted up; high*high falls off
  always_comb begin
    pa = ra[HW-1:0];
    pb = rb[HW-1:0];
    case (step)
      2'd0: begin
        pa = ra[HW-1:0];
        pb = rb[HW-1:0];
      end
      2'd1: begin
        pa = ra[HW-1:0];
        pb = rb[ACC_W-1:HW];
      end
      2'd2: begin
        pa = ra[ACC_W-1:HW];
        pb = rb[HW-1:0];
      end
      default: begin
        pa = ra[HW-1:0];
        pb = rb[HW-1:0];
      end
    endcase
    prod = pa * pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
    end else if (busy) begin
      if (step == 2'd0) begin
        p <= prod;
      end else begin
        p <= p + {prod[HW-1:0], {HW{1'b0}}};
      end
    end
  end

endmodule

### rtl/mlm_dp.sv
// mlm_dp: datapath of the local-move core: cluster map, cluster weights,
// tallies, neighbor buffer, accumulators and result registers.
// Depends on mlm_pkg and mlm_mul; driven by opcodes from mlm_ctrl.
module mlm_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  mlm_pkg::dp_cmd_t           cmd,
  output mlm_pkg::dp_stat_t          st,
  input  logic                       cfg_we,
  input  logic [mlm_pkg::CW_W-1:0]   cfg_data,
  input  logic [1:0]                 mode,
  input  logic [mlm_pkg::VID_W-1:0]  vertex,
  input  logic [mlm_pkg::WT_W-1:0]   self_weight,
  input  logic [mlm_pkg::WT_W-1:0]   init_self,
  input  logic [mlm_pkg::VID_W-1:0]  neighbor,
  input  logic [mlm_pkg::WT_W-1:0]   edge_weight,
  input  logic [mlm_pkg::VID_W-1:0]  target_cluster,
  output logic                       moved,
  output logic [mlm_pkg::VID_W-1:0]  new_cluster,
  output logic [mlm_pkg::ACC_W-1:0]  gain,
  output logic [mlm_pkg::ACC_W-1:0]  modularity_sum,
  output logic [mlm_pkg::CNT_W-1:0]  clusters,
  output logic                       status
);
  import mlm_pkg::*;

  localparam int XW = ACC_W - CW_W;
  localparam int SW = ACC_W - WT_W;
  localparam int EW = CW_W - WT_W;

  // memories
  logic [VID_W-1:0] cof_mem [NV];
  logic [CW_W-1:0]  cw_mem  [NV];
  logic [CW_W-1:0]  tal_mem [NV];
  logic [VID_W-1:0] nb_mem  [MAX_DEG];

  logic             cof_we;
  logic [VID_W-1:0] cof_wa, cof_wd, cof_ra, cof_rd;
  logic             cw_we;
  logic [VID_W-1:0] cw_wa, cw_ra;
  logic [CW_W-1:0]  cw_wd, cw_rd;
  logic             tal_we;
  logic [VID_W-1:0] tal_wa, tal_ra;
  logic [CW_W-1:0]  tal_wd, tal_rd;
  logic             nb_we;
  logic [DEG_W-1:0] nb_wa, nb_ra;
  logic [VID_W-1:0] nb_wd, nb_rd;

  // control registers
  logic [CW_W-1:0]  tw;
  logic [VID_W-1:0] clr;
  logic [EC_W-1:0]  edge_count;
  logic [CW_W-1:0]  vwacc;
  logic [CW_W-1:0]  own;
  logic [ACC_W-1:0] macc;
  logic [CNT_W-1:0] ctotal;

  // item and working registers
  logic [1:0]       i_mode;
  logic [VID_W-1:0] i_u, i_nb, i_tc;
  logic [WT_W-1:0]  i_sw, i_isw, i_ew;
  logic [VID_W-1:0] c_old, c, c_best;
  logic [CW_W-1:0]  vw, cw_old, tin, cwc, cwn;
  logic [EC_W-1:0]  idx;
  logic [ACC_W-1:0] best, gacc;
  logic             found;
  logic             r_moved, r_status;
  logic [VID_W-1:0] r_newc;
  logic [ACC_W-1:0] r_gain;

  // multiplier
  logic             mul_start, mul_done;
  logic [ACC_W-1:0] mul_a, mul_b, mul_p;
  logic [ACC_W-1:0] tin_diff, cw_diff, gsum;
  logic [CNT_W-1:0] ct_move;

  mlm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign tin_diff = {{XW{1'b0}}, tin} - {{XW{1'b0}}, own};
  assign cw_diff  = {{XW{1'b0}}, cw_old} - {{XW{1'b0}}, cwc} - {{XW{1'b0}}, vw};
  assign gsum     = gacc + mul_p;
  assign ct_move  = ctotal - {{(CNT_W-1){1'b0}}, (cw_old == vw)}
                           + {{(CNT_W-1){1'b0}}, (cw_rd == '0)};

  always_comb begin
    mul_start = 1'b0;
    mul_a     = {{XW{1'b0}}, tw};
    mul_b     = {{SW{1'b0}}, i_isw};
    case (cmd.op)
      OP_INIT_M1: begin
        mul_start = 1'b1;
        mul_a     = {{XW{1'b0}}, tw};
        mul_b     = {{SW{1'b0}}, i_isw};
      end
      OP_INIT_M2: begin
        mul_start = 1'b1;
        mul_a     = {{SW{1'b0}}, i_sw};
        mul_b     = {{SW{1'b0}}, i_sw};
      end
      OP_G_M1: begin
        mul_start = 1'b1;
        mul_a     = {{XW{1'b0}}, tw};
        mul_b     = {tin_diff[ACC_W-2:0], 1'b0};
      end
      OP_G_M2: begin
        mul_start = 1'b1;
        mul_a     = {{XW{1'b0}}, vw};
        mul_b     = {cw_diff[ACC_W-2:0], 1'b0};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    cof_we = 1'b0;  cof_wa = i_u;  cof_wd = i_u;  cof_ra = i_u;
    cw_we  = 1'b0;  cw_wa  = clr;  cw_wd  = '0;   cw_ra  = c_best;
    tal_we = 1'b0;  tal_wa = clr;  tal_wd = '0;   tal_ra = c_old;
    nb_we  = 1'b0;  nb_wa  = edge_count[DEG_W-1:0];
    nb_wd  = c;     nb_ra  = idx[DEG_W-1:0];
    case (cmd.op)
      OP_CLR: begin
        cw_we  = 1'b1;
        tal_we = 1'b1;
      end
      OP_INIT_FIN: begin
        cof_we = 1'b1;
        cw_we  = 1'b1;
        cw_wa  = i_u;
        cw_wd  = {{EW{1'b0}}, i_sw};
      end
      OP_EDGE_R1: cof_ra = i_nb;
      OP_EDGE_R2: tal_ra = cof_rd;
      OP_EDGE_FIN: begin
        tal_we = 1'b1;
        tal_wa = c;
        tal_wd = tal_rd + {{EW{1'b0}}, i_ew};
        nb_we  = 1'b1;
      end
      OP_MV_R1: cof_ra = i_u;
      OP_MV_R2: begin
        tal_ra = cof_rd;
        cw_ra  = cof_rd;
      end
      OP_MV_OWN: begin
        tal_we = 1'b1;
        tal_wa = c_old;
      end
      OP_WALK_CL: begin
        tal_ra = nb_rd;
        cw_ra  = nb_rd;
      end
      OP_WALK_CHK: begin
        tal_we = (tal_rd != '0);
        tal_wa = c;
      end
      OP_F_RD: begin
        tal_ra = i_tc;
        cw_ra  = i_tc;
      end
      OP_AP_R: cw_ra = c_best;
      OP_AP_1: begin
        cw_we  = 1'b1;
        cw_wa  = c_old;
        cw_wd  = cw_old - vw;
        cof_we = 1'b1;
        cof_wd = c_best;
      end
      OP_AP_2: begin
        cw_we = 1'b1;
        cw_wa = c_best;
        cw_wd = cwn + vw;
      end
      OP_FC_WR: begin
        tal_we = 1'b1;
        tal_wa = nb_rd;
      end
      default: begin
        cof_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[cof_wa] <= cof_wd;
    end
    cof_rd <= cof_mem[cof_ra];
  end

  always_ff @(posedge clk) begin
    if (cw_we) begin
      cw_mem[cw_wa] <= cw_wd;
    end
    cw_rd <= cw_mem[cw_ra];
  end

  always_ff @(posedge clk) begin
    if (tal_we) begin
      tal_mem[tal_wa] <= tal_wd;
    end
    tal_rd <= tal_mem[tal_ra];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_wa] <= nb_wd;
    end
    nb_rd <= nb_mem[nb_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tw         <= '0;
      clr        <= '0;
      edge_count <= '0;
      vwacc      <= '0;
      own        <= '0;
      macc       <= '0;
      ctotal     <= '0;
    end else begin
      if (cfg_we) begin
        tw <= cfg_data;
      end
      case (cmd.op)
        OP_CLR: clr <= clr + 1'b1;
        OP_INIT_FIN: begin
          macc   <= macc + gacc - mul_p;
          ctotal <= ctotal + 1'b1;
        end
        OP_EDGE_FIN: begin
          edge_count <= edge_count + 1'b1;
          vwacc      <= vwacc + {{EW{1'b0}}, i_ew};
        end
        OP_MV_OWN: own <= tal_rd;
        OP_AP_1: begin
          macc   <= macc + best;
          ctotal <= ct_move;
        end
        OP_FIN: begin
          edge_count <= '0;
          vwacc      <= '0;
          own        <= '0;
        end
        default: begin
          clr <= clr;
        end
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        i_mode   <= mode;
        i_u      <= vertex;
        i_sw     <= self_weight;
        i_isw    <= init_self;
        i_nb     <= neighbor;
        i_ew     <= edge_weight;
        i_tc     <= target_cluster;
        r_moved  <= 1'b0;
        r_newc   <= '0;
        r_gain   <= '0;
        r_status <= 1'b0;
      end
      OP_INIT_M2:   gacc <= mul_p;
      OP_INIT_FIN:  r_newc <= i_u;
      OP_EDGE_R2:   c <= cof_rd;
      OP_EDGE_FULL: r_status <= 1'b1;
      OP_MV_R2: begin
        c_old <= cof_rd;
        vw    <= {{EW{1'b0}}, i_sw} + vwacc;
      end
      OP_MV_OWN: begin
        cw_old <= cw_rd;
        best   <= '0;
        found  <= 1'b0;
        c_best <= c_old;
        idx    <= '0;
      end
      OP_WALK_CL: c <= nb_rd;
      OP_WALK_CHK: begin
        tin <= tal_rd;
        cwc <= cw_rd;
        idx <= idx + 1'b1;
      end
      OP_F_LD: begin
        tin <= tal_rd;
        cwc <= cw_rd;
        c   <= i_tc;
      end
      OP_G_M2: gacc <= mul_p;
      OP_G_CMP: begin
        // forced moves apply whatever the gain; decide keeps the first best
        if (i_mode == MODE_FORCE || $signed(gsum) > $signed(best)) begin
          best   <= gsum;
          c_best <= c;
          found  <= 1'b1;
        end
      end
      OP_AP_1: begin
        cwn     <= cw_rd;
        r_moved <= 1'b1;
        r_gain  <= best;
      end
      OP_FC_WR: idx <= idx + 1'b1;
      OP_FIN:   r_newc <= found ? c_best : c_old;
      OP_RESULT: begin
        moved          <= r_moved;
        new_cluster    <= r_newc;
        gain           <= r_gain;
        modularity_sum <= macc;
        clusters       <= ctotal;
        status         <= r_status;
      end
      default: begin
        i_mode <= i_mode;
      end
    endcase
  end

  always_comb begin
    st.mode         = i_mode;
    st.edge_full    = edge_count[DEG_W];
    st.walk_end     = (idx == edge_count);
    st.tin_zero     = (tal_rd == '0);
    st.same_cluster = (i_tc == c_old);
    st.found        = found;
    st.mul_done     = mul_done;
    st.clr_done     = (clr == VID_W'(NV - 1));
  end

endmodule

### rtl/mlm_ctrl.sv
// mlm_ctrl: sequencing state machine for the local-move core; issues
// datapath opcodes and owns the input and output handshakes. Depends on mlm_pkg.
module mlm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output mlm_pkg::dp_cmd_t   cmd,
  input  mlm_pkg::dp_stat_t  st
);
  import mlm_pkg::*;

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DISPATCH  = 5'd2;
  localparam logic [4:0] S_INIT_M1   = 5'd3;
  localparam logic [4:0] S_INIT_W1   = 5'd4;
  localparam logic [4:0] S_INIT_M2   = 5'd5;
  localparam logic [4:0] S_INIT_W2   = 5'd6;
  localparam logic [4:0] S_INIT_FIN  = 5'd7;
  localparam logic [4:0] S_EDGE_FULL = 5'd8;
  localparam logic [4:0] S_EDGE_R1   = 5'd9;
  localparam logic [4:0] S_EDGE_R2   = 5'd10;
  localparam logic [4:0] S_EDGE_FIN  = 5'd11;
  localparam logic [4:0] S_MV_R1     = 5'd12;
  localparam logic [4:0] S_MV_R2     = 5'd13;
  localparam logic [4:0] S_MV_OWN    = 5'd14;
  localparam logic [4:0] S_WALK_RD   = 5'd15;
  localparam logic [4:0] S_WALK_CL   = 5'd16;
  localparam logic [4:0] S_WALK_CHK  = 5'd17;
  localparam logic [4:0] S_F_RD      = 5'd18;
  localparam logic [4:0] S_F_LD      = 5'd19;
  localparam logic [4:0] S_G_M1      = 5'd20;
  localparam logic [4:0] S_G_W1      = 5'd21;
  localparam logic [4:0] S_G_M2      = 5'd22;
  localparam logic [4:0] S_G_W2      = 5'd23;
  localparam logic [4:0] S_G_CMP     = 5'd24;
  localparam logic [4:0] S_AP_R      = 5'd25;
  localparam logic [4:0] S_AP_1      = 5'd26;
  localparam logic [4:0] S_AP_2      = 5'd27;
  localparam logic [4:0] S_FC_RD     = 5'd28;
  localparam logic [4:0] S_FC_WR     = 5'd29;
  localparam logic [4:0] S_FIN       = 5'd30;
  localparam logic [4:0] S_DONE      = 5'd31;

  logic [4:0] state, state_next;
  logic       out_free;
  logic       decide;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign decide   = (st.mode == MODE_DECIDE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.mode)
          MODE_INIT: state_next = S_INIT_M1;
          MODE_EDGE: state_next = st.edge_full ? S_EDGE_FULL : S_EDGE_R1;
          default:   state_next = S_MV_R1;
        endcase
      end
      S_INIT_M1: begin
        cmd.op     = OP_INIT_M1;
        state_next = S_INIT_W1;
      end
      S_INIT_W1: if (st.mul_done) state_next = S_INIT_M2;
      S_INIT_M2: begin
        cmd.op     = OP_INIT_M2;
        state_next = S_INIT_W2;
      end
      S_INIT_W2: if (st.mul_done) state_next = S_INIT_FIN;
      S_INIT_FIN: begin
        cmd.op     = OP_INIT_FIN;
        state_next = S_DONE;
      end
      S_EDGE_FULL: begin
        cmd.op     = OP_EDGE_FULL;
        state_next = S_DONE;
      end
      S_EDGE_R1: begin
        cmd.op     = OP_EDGE_R1;
        state_next = S_EDGE_R2;
      end
      S_EDGE_R2: begin
        cmd.op     = OP_EDGE_R2;
        state_next = S_EDGE_FIN;
      end
      S_EDGE_FIN: begin
        cmd.op     = OP_EDGE_FIN;
        state_next = S_DONE;
      end
      S_MV_R1: begin
        cmd.op     = OP_MV_R1;
        state_next = S_MV_R2;
      end
      S_MV_R2: begin
        cmd.op     = OP_MV_R2;
        state_next = S_MV_OWN;
      end
      S_MV_OWN: begin
        cmd.op = OP_MV_OWN;
        if (decide) state_next = S_WALK_RD;
        else if (st.same_cluster) state_next = S_FC_RD;
        else state_next = S_F_RD;
      end
      S_WALK_RD: begin
        if (st.walk_end) begin
          state_next = st.found ? S_AP_R : S_FIN;
        end else begin
          cmd.op     = OP_WALK_RD;
          state_next = S_WALK_CL;
        end
      end
      S_WALK_CL: begin
        cmd.op     = OP_WALK_CL;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        // zero tally means cluster already visited or never tallied
        cmd.op     = OP_WALK_CHK;
        state_next = st.tin_zero ? S_WALK_RD : S_G_M1;
      end
      S_F_RD: begin
        cmd.op     = OP_F_RD;
        state_next = S_F_LD;
      end
      S_F_LD: begin
        cmd.op     = OP_F_LD;
        state_next = S_G_M1;
      end
      S_G_M1: begin
        cmd.op     = OP_G_M1;
        state_next = S_G_W1;
      end
      S_G_W1: if (st.mul_done) state_next = S_G_M2;
      S_G_M2: begin
        cmd.op     = OP_G_M2;
        state_next = S_G_W2;
      end
      S_G_W2: if (st.mul_done) state_next = S_G_CMP;
      S_G_CMP: begin
        cmd.op     = OP_G_CMP;
        state_next = decide ? S_WALK_RD : S_AP_R;
      end
      S_AP_R: begin
        cmd.op     = OP_AP_R;
        state_next = S_AP_1;
      end
      S_AP_1: begin
        cmd.op     = OP_AP_1;
        state_next = S_AP_2;
      end
      S_AP_2: begin
        cmd.op     = OP_AP_2;
        state_next = decide ? S_FIN : S_FC_RD;
      end
      S_FC_RD: begin
        if (st.walk_end) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_FC_RD;
          state_next = S_FC_WR;
        end
      end
      S_FC_WR: begin
        cmd.op     = OP_FC_WR;
        state_next = S_FC_RD;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/modularity_local_move_core.sv
// modularity_local_move_core: top level of the modularity local-move engine.
// Depends on mlm_pkg, mlm_ctrl, mlm_dp (which holds mlm_mul).
//
//   channel  signals                        transfer when
//   in       in_valid / in_stall + fields   in_valid && !in_stall
//   out      out_valid / out_stall + fields out_valid && !out_stall
//   cfg      cfg_valid / cfg_ready          cfg_valid && cfg_ready
//
// one item at a time; the multiplier, run twice per gain, sets the gain cost,
// and input is taken again in the cycle after the result is issued.
// after reset a clearing pass zeroes cluster weights and tallies with in_stall
// high. a new item is taken while a result waits on a stalled output; the next
// result waits until that one transfers.
module modularity_local_move_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [mlm_pkg::VID_W-1:0]  vertex,
  input  logic [mlm_pkg::WT_W-1:0]   self_weight,
  input  logic [mlm_pkg::WT_W-1:0]   init_self,
  input  logic [mlm_pkg::VID_W-1:0]  neighbor,
  input  logic [mlm_pkg::WT_W-1:0]   edge_weight,
  input  logic [mlm_pkg::VID_W-1:0]  target_cluster,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       moved,
  output logic [mlm_pkg::VID_W-1:0]  new_cluster,
  output logic [mlm_pkg::ACC_W-1:0]  gain,
  output logic [mlm_pkg::ACC_W-1:0]  modularity_sum,
  output logic [mlm_pkg::CNT_W-1:0]  clusters,
  output logic                       status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mlm_pkg::CW_W-1:0]   total_weight
);
  import mlm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  mlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  mlm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (total_weight),
    .mode           (mode),
    .vertex         (vertex),
    .self_weight    (self_weight),
    .init_self      (init_self),
    .neighbor       (neighbor),
    .edge_weight    (edge_weight),
    .target_cluster (target_cluster),
    .moved          (moved),
    .new_cluster    (new_cluster),
    .gain           (gain),
    .modularity_sum (modularity_sum),
    .clusters       (clusters),
    .status         (status)
  );

  // clearing pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_drop_no_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !moved && gain == '0)
    else $error("dropped edge reports a move");

  a_gain_needs_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && !moved |-> gain == '0)
    else $error("nonzero gain without a move");

endmodule

### test/modularity_local_move_core_tb.sv
// modularity_local_move_core_tb: self-checking bench for the local-move engine.
// Depends on mlm_pkg and modularity_local_move_core; keeps its own cluster-state
// predictor and checks every output transfer against the queue of predicted results.
module modularity_local_move_core_tb;
  import mlm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VID_W-1:0] vertex;
    logic [WT_W-1:0]  self_w;
    logic [WT_W-1:0]  own_w;
    logic [VID_W-1:0] nbr;
    logic [WT_W-1:0]  edge_w;
    logic [VID_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic             moved;
    logic [VID_W-1:0] cluster;
    logic [ACC_W-1:0] gain;
    logic [ACC_W-1:0] msum;
    logic [CNT_W-1:0] count;
    logic             status;
  } move_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] mode = MODE_INIT;
  logic [VID_W-1:0] vertex = '0;
  logic [WT_W-1:0] self_weight = '0;
  logic [WT_W-1:0] init_self = '0;
  logic [VID_W-1:0] neighbor = '0;
  logic [WT_W-1:0] edge_weight = '0;
  logic [VID_W-1:0] target_cluster = '0;
  logic out_valid;
  logic out_stall = 0;
  logic moved;
  logic [VID_W-1:0] new_cluster;
  logic [ACC_W-1:0] gain;
  logic [ACC_W-1:0] modularity_sum;
  logic [CNT_W-1:0] clusters;
  logic status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CW_W-1:0] total_weight = '0;

  modularity_local_move_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .vertex(vertex), .self_weight(self_weight), .init_self(init_self),
    .neighbor(neighbor), .edge_weight(edge_weight), .target_cluster(target_cluster),
    .out_valid(out_valid), .out_stall(out_stall),
    .moved(moved), .new_cluster(new_cluster), .gain(gain),
    .modularity_sum(modularity_sum), .clusters(clusters), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .total_weight(total_weight)
  );

  always #5 clk = ~clk;

  // predicted cluster state
  logic [VID_W-1:0] owner_cl [NV];
  logic [CW_W-1:0]  cl_weight [NV];
  logic [CW_W-1:0]  link_sum [NV];
  logic [VID_W-1:0] nbr_cl [MAX_DEG];
  int               nbr_count;
  logic [CW_W-1:0]  edge_w_sum;
  logic [CW_W-1:0]  old_link;
  logic [ACC_W-1:0] mod_num;
  logic [CNT_W-1:0] cl_count;
  logic [CW_W-1:0]  graph_weight;

  move_result_t expected_q[$];
  int errors;
  int cycles;
  int hold_cycles;
  int stall_left;
  bit tx_gaps;
  bit rx_gaps;

  function automatic logic [ACC_W-1:0] move_delta(logic [VID_W-1:0] c_old,
      logic [VID_W-1:0] c_new, logic [CW_W-1:0] in_new, logic [CW_W-1:0] vw);
    logic [ACC_W-1:0] a, b;
    a = 64'd2 * ACC_W'(graph_weight) * (ACC_W'(in_new) - ACC_W'(old_link));
    b = 64'd2 * ACC_W'(vw) *
        (ACC_W'(cl_weight[c_old]) - ACC_W'(cl_weight[c_new]) - ACC_W'(vw));
    return a + b;
  endfunction

  function automatic void commit_move(logic [VID_W-1:0] u, logic [VID_W-1:0] c_old,
      logic [VID_W-1:0] c_new, logic [CW_W-1:0] vw, logic [ACC_W-1:0] d);
    mod_num += d;
    if (cl_weight[c_old] == vw) cl_count -= 1;
    if (cl_weight[c_new] == 0) cl_count += 1;
    owner_cl[u] = c_new;
    cl_weight[c_old] = cl_weight[c_old] - vw;
    cl_weight[c_new] = cl_weight[c_new] + vw;
  endfunction

  function automatic move_result_t predict_move(item_t it);
    move_result_t r;
    logic [VID_W-1:0] c_old, c_best, c;
    logic [CW_W-1:0] vw, in_new;
    logic [ACC_W-1:0] best, d;
    bit found;
    r = '0;
    case (it.mode)
      MODE_INIT: begin
        owner_cl[it.vertex] = it.vertex;
        cl_weight[it.vertex] = CW_W'(it.self_w);
        mod_num += ACC_W'(graph_weight) * ACC_W'(it.own_w) -
                   ACC_W'(it.self_w) * ACC_W'(it.self_w);
        cl_count += 1;
        r.cluster = it.vertex;
      end
      MODE_EDGE: begin
        if (nbr_count >= MAX_DEG) begin
          r.status = 1;
        end else begin
          c = owner_cl[it.nbr];
          nbr_cl[nbr_count] = c;
          nbr_count++;
          link_sum[c] = link_sum[c] + CW_W'(it.edge_w);
          edge_w_sum = edge_w_sum + CW_W'(it.edge_w);
        end
      end
      default: begin
        c_old = owner_cl[it.vertex];
        vw = CW_W'(it.self_w) + edge_w_sum;
        old_link = link_sum[c_old];
        if (it.mode == MODE_DECIDE) begin
          best = '0;
          found = 0;
          c_best = c_old;
          link_sum[c_old] = '0;
          for (int i = 0; i < nbr_count; i++) begin
            c = nbr_cl[i];
            if (link_sum[c] != 0) begin
              in_new = link_sum[c];
              link_sum[c] = '0;
              d = move_delta(c_old, c, in_new, vw);
              if ($signed(d) > $signed(best)) begin
                best = d;
                c_best = c;
                found = 1;
              end
            end
          end
          if (found && best != 0) begin
            commit_move(it.vertex, c_old, c_best, vw, best);
            r.moved = 1;
            r.gain = best;
          end
        end else if (it.target != c_old) begin
          r.gain = move_delta(c_old, it.target, link_sum[it.target], vw);
          commit_move(it.vertex, c_old, it.target, vw, r.gain);
          r.moved = 1;
        end
        for (int i = 0; i < nbr_count; i++) link_sum[nbr_cl[i]] = '0;
        link_sum[c_old] = '0;
        nbr_count = 0;
        edge_w_sum = '0;
        old_link = '0;
        r.cluster = owner_cl[it.vertex];
      end
    endcase
    r.msum = mod_num;
    r.count = cl_count;
    return r;
  endfunction

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return WT_W'($urandom);
      default: return WT_W'($urandom_range(1, 50));
    endcase
  endfunction

  task automatic report(string field, logic [ACC_W-1:0] got, logic [ACC_W-1:0] exp);
    $display("mismatch %s: got %0h, expected %0h", field, got, exp);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    move_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(new_cluster), '0);
      end else begin
        e = expected_q.pop_front();
        if (moved !== e.moved) report("moved", 64'(moved), 64'(e.moved));
        if (new_cluster !== e.cluster) report("new_cluster", 64'(new_cluster), 64'(e.cluster));
        if (gain !== e.gain) report("gain", gain, e.gain);
        if (modularity_sum !== e.msum) report("modularity_sum", modularity_sum, e.msum);
        if (clusters !== e.count) report("clusters", 64'(clusters), 64'(e.count));
        if (status !== e.status) report("status", 64'(status), 64'(e.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("modularity_local_move_core_tb: errors");
      $finish;
    end
  end

  // receiver side stall
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1;
        stall_left--;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic send(item_t it);
    int n;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    mode <= it.mode;
    vertex <= it.vertex;
    self_weight <= it.self_w;
    init_self <= it.own_w;
    neighbor <= it.nbr;
    edge_weight <= it.edge_w;
    target_cluster <= it.target;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_move(it));
  endtask

  function automatic item_t noise_item(logic [1:0] m);
    item_t it;
    it = {m, VID_W'($urandom), WT_W'($urandom), WT_W'($urandom), VID_W'($urandom),
          WT_W'($urandom), VID_W'($urandom)};
    return it;
  endfunction

  task automatic do_init(logic [VID_W-1:0] v, logic [WT_W-1:0] sw, logic [WT_W-1:0] isw);
    item_t it;
    it = noise_item(MODE_INIT);
    it.vertex = v;
    it.self_w = sw;
    it.own_w = isw;
    send(it);
  endtask

  task automatic do_edge(logic [VID_W-1:0] nb, logic [WT_W-1:0] ew);
    item_t it;
    it = noise_item(MODE_EDGE);
    it.nbr = nb;
    it.edge_w = ew;
    send(it);
  endtask

  task automatic do_move(logic [1:0] m, logic [VID_W-1:0] v, logic [WT_W-1:0] sw,
      logic [VID_W-1:0] tc);
    item_t it;
    it = noise_item(m);
    it.vertex = v;
    it.self_w = sw;
    it.target = tc;
    send(it);
  endtask

  // stop offering items, then wait for every expected result
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_total_weight(logic [CW_W-1:0] v);
    drain();
    @(negedge clk);
    in_valid <= 0;
    cfg_valid <= 1;
    total_weight <= v;
    do @(posedge clk); while (!cfg_ready);
    graph_weight = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic test_directed();
    do_init(12'd0, 24'd3, 24'd0);
    do_init(12'd1, 24'd2, 24'd1);
    do_init(12'd2, 24'd2, 24'd0);
    do_init(12'hfff, 24'hffffff, 24'hffffff);
    do_init(12'd5, 24'd0, 24'd0);
    // neighbors mostly in one cluster, so a move should pay off
    do_edge(12'd1, 24'd1);
    do_edge(12'd2, 24'd1);
    do_edge(12'd1, 24'd5);
    do_move(MODE_DECIDE, 12'd0, 24'd0, '0);
    // empty buffer: nothing to gain
    do_move(MODE_DECIDE, 12'd2, 24'd0, '0);
    do_edge(12'hfff, 24'hffffff);
    do_edge(12'd0, 24'd0);
    do_move(MODE_FORCE, 12'd5, 24'd1, 12'd5);
    do_move(MODE_FORCE, 12'd1, 24'hffffff, 12'd2);
    do_move(MODE_FORCE, 12'd2, 24'd7, 12'd3000);
    do_init(12'd1, 24'd4, 24'd2);
    do_edge(12'd0, 24'd3);
    do_move(MODE_FORCE, 12'hfff, 24'd0, 12'd0);
    do_move(MODE_DECIDE, 12'd5, 24'hffffff, '0);
  endtask

  task automatic test_buffer_full();
    do_init(12'd10, 24'd1, 24'd0);
    do_init(12'd11, 24'd300, 24'd0);
    for (int i = 0; i < MAX_DEG + 2; i++) do_edge(12'd11, 24'd1);
    do_move(MODE_DECIDE, 12'd10, 24'd0, '0);
  endtask

  // long receiver hold-off while items keep coming, then a full drain
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) begin
      if (i % 5 == 4) do_move(MODE_DECIDE, 12'd10, 24'd1, '0);
      else do_edge($urandom_range(0, 1) ? 12'd11 : 12'd0, pick_weight());
    end
    drain();
  endtask

  task automatic test_random_graph(int rounds);
    logic [VID_W-1:0] pool [12];
    logic [VID_W-1:0] v;
    int k;
    foreach (pool[i]) begin
      pool[i] = VID_W'($urandom);
      do_init(pool[i], pick_weight(), pick_weight());
    end
    for (int r = 0; r < rounds; r++) begin
      v = pool[$urandom_range(0, 11)];
      k = $urandom_range(0, 8);
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(0, 15) == 0) do_init(pool[$urandom_range(0, 11)],
                                                pick_weight(), pick_weight());
        else do_edge(pool[$urandom_range(0, 11)], pick_weight());
      end
      case ($urandom_range(0, 9))
        0: do_move(MODE_FORCE, v, pick_weight(), VID_W'($urandom));
        1, 2: do_move(MODE_FORCE, v, pick_weight(), pool[$urandom_range(0, 11)]);
        default: do_move(MODE_DECIDE, v, pick_weight(), '0);
      endcase
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    stall_left = 0;
    nbr_count = 0;
    edge_w_sum = '0;
    old_link = '0;
    mod_num = '0;
    cl_count = '0;
    graph_weight = '0;
    foreach (owner_cl[i]) begin
      owner_cl[i] = '0;
      cl_weight[i] = '0;
      link_sum[i] = '0;
    end
    tx_gaps = 1;
    rx_gaps = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    set_total_weight(40'd40);
    test_directed();
    test_buffer_full();
    test_backpressure();
    set_total_weight('1);
    test_random_graph(6);
    set_total_weight('0);
    test_random_graph(6);
    set_total_weight(40'($urandom_range(1, 5000)));
    test_random_graph(4);
    // closing stretch with no idling on either side
    tx_gaps = 0;
    rx_gaps = 0;
    test_random_graph(4);

    @(negedge clk);
    in_valid <= 0;
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("modularity_local_move_core_tb: clean");
    end else begin
      $display("modularity_local_move_core_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mlm_pkg.sv
rtl/mlm_mul.sv
rtl/mlm_dp.sv
rtl/mlm_ctrl.sv
rtl/modularity_local_move_core.sv
test/modularity_local_move_core_tb.sv
